// ===== sv/owbm_pkg.sv =====
// Shared types and codes for the 1-Wire bus master.
// Item structs, opcodes and register indexes; no dependencies.
package owbm_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_RESET = 3'd1,
        OP_WBYTE = 3'd2,
        OP_RBYTE = 3'd3,
        OP_WBIT  = 3'd4,
        OP_RBIT  = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RECOVERY      = 3'd2,
        REG_WRITE_LEAD    = 3'd3,
        REG_SLOT          = 3'd4,
        REG_WRITE_TAIL    = 3'd5,
        REG_READ_LEAD     = 3'd6,
        REG_READ_SAMPLE   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       presence;
        logic       rejected;
    } out_item_t;

endpackage

// ===== sv/one_wire_bus_master.sv =====
// 1-Wire bus master: command/tick sequencer, slot timers and APB register file.
// Depends on owbm_pkg for item structs, opcodes and register indexes.
//
//  port group   handshake            payload
//  s_*          s_valid / s_ready    s_data  (owbm_pkg::in_item_t)
//  m_*          m_valid / m_ready    m_data  (owbm_pkg::out_item_t)
//  APB          psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle while s_ready is high: each item updates the phase, timer
// and shift state in the cycle it is accepted, and its result lands in the output register.
// The output register is the only stage, so s_ready is low only while a result
// waits with m_ready low. Synchronous active-low reset returns to idle with
// the default slot timings; no clearing pass is needed.
module one_wire_bus_master (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  owbm_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output owbm_pkg::out_item_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [owbm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import owbm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RLOW   = 4'd1,
        PH_RWAIT  = 4'd2,
        PH_RREC   = 4'd3,
        PH_WLEAD  = 4'd4,
        PH_WSLOT  = 4'd5,
        PH_WTAIL  = 4'd6,
        PH_RDLEAD = 4'd7,
        PH_RDWAIT = 4'd8,
        PH_RDHOLD = 4'd9
    } phase_t;

    // configuration
    logic [11:0] reset_low_us_reg;
    logic [9:0]  presence_wait_us_reg;
    logic [11:0] recovery_us_reg;
    logic [7:0]  write_lead_us_reg;
    logic [7:0]  slot_us_reg;
    logic [7:0]  write_tail_us_reg;
    logic [7:0]  read_lead_us_reg;
    logic [7:0]  read_sample_us_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [11:0] time_count_reg, time_count_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_data_reg, shift_data_next;
    logic [2:0]  active_cmd_reg, active_cmd_next;
    logic        presence_reg, presence_next;
    logic        line_pulled_reg, line_pulled_next;
    logic [7:0]  last_read_reg, last_read_next;

    out_item_t   m_data_reg, m_data_next;
    logic        m_valid_reg;

    logic        s_accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [3:0]  bit_count_inc;
    logic [3:0]  total_bits;
    logic        done_flag;
    logic        reject_flag;

    // a zero-length phase still lasts one tick
    function automatic logic [11:0] phase_len(input logic [11:0] len);
        return (len == 12'd0) ? 12'd1 : len;
    endfunction

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    assign bit_count_inc = bit_count_reg + 4'd1;
    assign total_bits    = (active_cmd_reg == OP_WBYTE || active_cmd_reg == OP_RBYTE)
                           ? 4'd8 : 4'd1;

    always_comb begin
        unique case (reg_index_t'(cfg_index))
            REG_RESET_LOW:     prdata = {20'd0, reset_low_us_reg};
            REG_PRESENCE_WAIT: prdata = {22'd0, presence_wait_us_reg};
            REG_RECOVERY:      prdata = {20'd0, recovery_us_reg};
            REG_WRITE_LEAD:    prdata = {24'd0, write_lead_us_reg};
            REG_SLOT:          prdata = {24'd0, slot_us_reg};
            REG_WRITE_TAIL:    prdata = {24'd0, write_tail_us_reg};
            REG_READ_LEAD:     prdata = {24'd0, read_lead_us_reg};
            REG_READ_SAMPLE:   prdata = {24'd0, read_sample_us_reg};
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        phase_next       = phase_reg;
        time_count_next  = time_count_reg;
        bit_count_next   = bit_count_reg;
        shift_data_next  = shift_data_reg;
        active_cmd_next  = active_cmd_reg;
        presence_next    = presence_reg;
        line_pulled_next = line_pulled_reg;
        last_read_next   = last_read_reg;
        done_flag        = 1'b0;
        reject_flag      = 1'b0;

        if (s_accept) begin
            if (s_data.opcode == OP_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    if (time_count_reg > 12'd1) begin
                        time_count_next = time_count_reg - 12'd1;
                    end else begin
                        // phase ends on this tick; fall to idle unless a next phase is set
                        done_flag        = 1'b1;
                        phase_next       = PH_IDLE;
                        time_count_next  = 12'd0;
                        line_pulled_next = 1'b0;
                        unique case (phase_reg)
                            PH_RLOW: begin
                                done_flag       = 1'b0;
                                phase_next      = PH_RWAIT;
                                time_count_next = phase_len({2'd0, presence_wait_us_reg});
                            end
                            PH_RWAIT: begin
                                presence_next = !s_data.line_level;
                                if (!s_data.line_level) begin
                                    done_flag       = 1'b0;
                                    phase_next      = PH_RREC;
                                    time_count_next = phase_len(recovery_us_reg);
                                end
                            end
                            PH_WLEAD: begin
                                done_flag        = 1'b0;
                                phase_next       = PH_WSLOT;
                                time_count_next  = phase_len({4'd0, slot_us_reg});
                                line_pulled_next = !shift_data_reg[0];
                            end
                            PH_WSLOT: begin
                                done_flag       = 1'b0;
                                phase_next      = PH_WTAIL;
                                time_count_next = phase_len({4'd0, write_tail_us_reg});
                            end
                            PH_WTAIL: begin
                                shift_data_next = {1'b0, shift_data_reg[7:1]};
                                bit_count_next  = bit_count_inc;
                                if (bit_count_inc < total_bits) begin
                                    done_flag        = 1'b0;
                                    phase_next       = PH_WLEAD;
                                    time_count_next  = phase_len({4'd0, write_lead_us_reg});
                                    line_pulled_next = 1'b1;
                                end
                            end
                            PH_RDLEAD: begin
                                done_flag       = 1'b0;
                                phase_next      = PH_RDWAIT;
                                time_count_next = phase_len({4'd0, read_sample_us_reg});
                            end
                            PH_RDWAIT: begin
                                done_flag = 1'b0;
                                if (active_cmd_reg == OP_RBYTE) begin
                                    shift_data_next = {s_data.line_level, shift_data_reg[7:1]};
                                end else begin
                                    shift_data_next = {7'd0, s_data.line_level};
                                end
                                phase_next      = PH_RDHOLD;
                                time_count_next = phase_len({4'd0, slot_us_reg});
                            end
                            PH_RDHOLD: begin
                                bit_count_next = bit_count_inc;
                                if (bit_count_inc < total_bits) begin
                                    done_flag        = 1'b0;
                                    phase_next       = PH_RDLEAD;
                                    time_count_next  = phase_len({4'd0, read_lead_us_reg});
                                    line_pulled_next = 1'b1;
                                end else begin
                                    last_read_next = shift_data_reg;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end else if (s_data.opcode <= OP_RBIT) begin
                if (phase_reg != PH_IDLE) begin
                    reject_flag = 1'b1;
                end else begin
                    active_cmd_next  = s_data.opcode;
                    bit_count_next   = 4'd0;
                    line_pulled_next = 1'b1;
                    unique case (opcode_t'(s_data.opcode))
                        OP_RESET: begin
                            phase_next      = PH_RLOW;
                            time_count_next = phase_len(reset_low_us_reg);
                        end
                        OP_WBYTE: begin
                            shift_data_next = s_data.data_byte;
                            phase_next      = PH_WLEAD;
                            time_count_next = phase_len({4'd0, write_lead_us_reg});
                        end
                        OP_WBIT: begin
                            shift_data_next = {7'd0, s_data.data_byte[0]};
                            phase_next      = PH_WLEAD;
                            time_count_next = phase_len({4'd0, write_lead_us_reg});
                        end
                        default: begin
                            shift_data_next = 8'd0;
                            phase_next      = PH_RDLEAD;
                            time_count_next = phase_len({4'd0, read_lead_us_reg});
                        end
                    endcase
                end
            end
        end

        m_data_next.drive_low = line_pulled_next;
        m_data_next.busy_res  = (phase_next != PH_IDLE);
        m_data_next.done_res  = done_flag;
        m_data_next.read_data = last_read_next;
        m_data_next.presence  = presence_next;
        m_data_next.rejected  = reject_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_us_reg     <= 12'd650;
            presence_wait_us_reg <= 10'd100;
            recovery_us_reg      <= 12'd2000;
            write_lead_us_reg    <= 8'd5;
            slot_us_reg          <= 8'd70;
            write_tail_us_reg    <= 8'd9;
            read_lead_us_reg     <= 8'd2;
            read_sample_us_reg   <= 8'd1;
        end else if (cfg_write) begin
            unique case (reg_index_t'(cfg_index))
                REG_RESET_LOW:     reset_low_us_reg     <= pwdata[11:0];
                REG_PRESENCE_WAIT: presence_wait_us_reg <= pwdata[9:0];
                REG_RECOVERY:      recovery_us_reg      <= pwdata[11:0];
                REG_WRITE_LEAD:    write_lead_us_reg    <= pwdata[7:0];
                REG_SLOT:          slot_us_reg          <= pwdata[7:0];
                REG_WRITE_TAIL:    write_tail_us_reg    <= pwdata[7:0];
                REG_READ_LEAD:     read_lead_us_reg     <= pwdata[7:0];
                REG_READ_SAMPLE:   read_sample_us_reg   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            time_count_reg  <= 12'd0;
            bit_count_reg   <= 4'd0;
            shift_data_reg  <= 8'd0;
            active_cmd_reg  <= 3'd0;
            presence_reg    <= 1'b0;
            line_pulled_reg <= 1'b0;
            last_read_reg   <= 8'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            time_count_reg  <= time_count_next;
            bit_count_reg   <= bit_count_next;
            shift_data_reg  <= shift_data_next;
            active_cmd_reg  <= active_cmd_next;
            presence_reg    <= presence_next;
            line_pulled_reg <= line_pulled_next;
            last_read_reg   <= last_read_next;
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken; load only with an accepted item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== verif/one_wire_bus_master_tb.sv =====
// Self-checking testbench for the 1-Wire bus master: random command and tick
// traffic, APB timing setups, a bus sequencer model in the tb stepped per accepted item.
// Depends on owbm_pkg and one_wire_bus_master; needs nothing else.
module one_wire_bus_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_PRINTS = 30;
    localparam int RANDOM_ITEMS = 1000;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int REG_WIDTH[8] = '{12, 10, 12, 8, 8, 8, 8, 8};
    localparam int REG_RESET_VAL[8] = '{650, 100, 2000, 5, 70, 9, 2, 1};

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_PRES_WAIT, PH_RECOVER, PH_WR_LEAD, PH_WR_SLOT,
        PH_WR_TAIL, PH_RD_LEAD, PH_RD_WAIT, PH_RD_HOLD
    } bus_phase_t;

    typedef enum int {SET_ZERO, SET_DEFAULT, SET_MAX, SET_RANDOM} setting_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    one_wire_bus_master dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Sequencer model state and timing registers
    logic [11:0] cfg [8];
    bus_phase_t ph = PH_IDLE;
    logic [11:0] tmr = '0;
    logic [3:0] nbits = '0;
    logic [7:0] shreg = '0;
    opcode_t cmd = OP_TICK;
    logic pres = 1'b0;
    logic line_low = 1'b0;
    logic [7:0] rd_last = '0;

    in_item_t cmd_tick_q[$];
    out_item_t bus_status_q[$];
    int items_queued = 0;
    int mismatches = 0;
    int results_seen = 0;
    int tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
    bit long_hold_done = 1'b0;
    int idle_cycles = 0;

    function automatic void go(bus_phase_t next, logic [11:0] len, logic low);
        ph = next;
        tmr = (len == 0) ? 12'd1 : len;
        line_low = low;
    endfunction

    function automatic int cmd_bits();
        return (cmd == OP_WBYTE || cmd == OP_RBYTE) ? 8 : 1;
    endfunction

    // Act on the tick that ends the current phase; 1 when the command completes
    function automatic bit end_of_phase(logic level);
        case (ph)
            PH_RST_LOW: begin
                go(PH_PRES_WAIT, cfg[REG_PRESENCE_WAIT], 1'b0);
                return 1'b0;
            end
            PH_PRES_WAIT: begin
                pres = !level;
                if (pres) begin
                    go(PH_RECOVER, cfg[REG_RECOVERY], 1'b0);
                    return 1'b0;
                end
            end
            PH_WR_LEAD: begin
                go(PH_WR_SLOT, cfg[REG_SLOT], !shreg[0]);
                return 1'b0;
            end
            PH_WR_SLOT: begin
                go(PH_WR_TAIL, cfg[REG_WRITE_TAIL], 1'b0);
                return 1'b0;
            end
            PH_WR_TAIL: begin
                shreg = shreg >> 1;
                nbits = nbits + 1'b1;
                if (nbits < cmd_bits()) begin
                    go(PH_WR_LEAD, cfg[REG_WRITE_LEAD], 1'b1);
                    return 1'b0;
                end
            end
            PH_RD_LEAD: begin
                go(PH_RD_WAIT, cfg[REG_READ_SAMPLE], 1'b0);
                return 1'b0;
            end
            PH_RD_WAIT: begin
                if (cmd == OP_RBYTE) shreg = {level, shreg[7:1]};
                else shreg = {7'd0, level};
                go(PH_RD_HOLD, cfg[REG_SLOT], 1'b0);
                return 1'b0;
            end
            PH_RD_HOLD: begin
                nbits = nbits + 1'b1;
                if (nbits < cmd_bits()) begin
                    go(PH_RD_LEAD, cfg[REG_READ_LEAD], 1'b1);
                    return 1'b0;
                end
                rd_last = shreg;
            end
            default: ;
        endcase
        ph = PH_IDLE;
        tmr = '0;
        line_low = 1'b0;
        return 1'b1;
    endfunction

    // Advance the model by one accepted item and return the status it produces
    function automatic out_item_t bus_step(in_item_t it);
        out_item_t r;
        logic done, rej;
        done = 1'b0;
        rej = 1'b0;
        if (it.opcode == OP_TICK) begin
            if (ph != PH_IDLE) begin
                if (tmr > 1) tmr = tmr - 1'b1;
                else done = end_of_phase(it.line_level);
            end
        end else if (it.opcode <= OP_RBIT) begin
            if (ph != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                cmd = opcode_t'(it.opcode);
                nbits = '0;
                case (cmd)
                    OP_RESET: go(PH_RST_LOW, cfg[REG_RESET_LOW], 1'b1);
                    OP_WBYTE: begin
                        shreg = it.data_byte;
                        go(PH_WR_LEAD, cfg[REG_WRITE_LEAD], 1'b1);
                    end
                    OP_WBIT: begin
                        shreg = {7'd0, it.data_byte[0]};
                        go(PH_WR_LEAD, cfg[REG_WRITE_LEAD], 1'b1);
                    end
                    default: begin
                        shreg = '0;
                        go(PH_RD_LEAD, cfg[REG_READ_LEAD], 1'b1);
                    end
                endcase
            end
        end
        r.drive_low = line_low;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = done;
        r.read_data = rd_last;
        r.presence = pres;
        r.rejected = rej;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int gap_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Stimulus driver: present queued items, run the model at each acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bus_status_q.push_back(bus_step(s_data));
                tx_gap = gap_len(tx_calm);
            end else if (!s_valid && tx_gap > 0) begin
                tx_gap--;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap == 0 && cmd_tick_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= cmd_tick_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (bus_status_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", m_data, 0);
                end else begin
                    want = bus_status_q.pop_front();
                    if (m_data.drive_low !== want.drive_low)
                        flag_mismatch("drive_low", m_data.drive_low, want.drive_low);
                    if (m_data.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", m_data.busy_res, want.busy_res);
                    if (m_data.done_res !== want.done_res)
                        flag_mismatch("done_res", m_data.done_res, want.done_res);
                    if (m_data.read_data !== want.read_data)
                        flag_mismatch("read_data", m_data.read_data, want.read_data);
                    if (m_data.presence !== want.presence)
                        flag_mismatch("presence", m_data.presence, want.presence);
                    if (m_data.rejected !== want.rejected)
                        flag_mismatch("rejected", m_data.rejected, want.rejected);
                end
                rx_stall = gap_len(rx_calm);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            // hold off long enough to back up the input side
            if (!long_hold_done && results_seen >= LONG_HOLD) begin
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD;
            end
            m_ready <= (rx_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[one_wire_bus_master] ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(logic [2:0] op, logic [7:0] d, logic lvl);
        in_item_t it;
        it.opcode = op;
        it.data_byte = d;
        it.line_level = lvl;
        cmd_tick_q.push_back(it);
        items_queued++;
    endtask

    task automatic apb_write(reg_index_t idx, logic [11:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(idx));
        pwdata <= {20'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg[idx] = v;
    endtask

    task automatic apply_setting(setting_t how);
        int i, r;
        logic [11:0] v;
        for (i = 0; i < 8; i++) begin
            r = $urandom_range(0, 99);
            case (how)
                SET_ZERO: v = '0;
                SET_DEFAULT: v = 12'(REG_RESET_VAL[i]);
                SET_MAX: v = 12'((1 << REG_WIDTH[i]) - 1);
                default: begin
                    if (r < 70) v = 12'($urandom_range(0, 4));
                    else if (r < 95) v = 12'($urandom_range(5, 24));
                    else v = 12'($urandom_range(25, 120));
                end
            endcase
            apply_one: apb_write(reg_index_t'(i), v);
        end
    endtask

    // Idle on both sides: nothing queued, nothing in flight, nothing expected
    task automatic wait_drained();
        while (cmd_tick_q.size() != 0 || s_valid || bus_status_q.size() != 0)
            @(negedge aclk);
    endtask

    function automatic int span(reg_index_t r);
        return (cfg[r] == 0) ? 1 : int'(cfg[r]);
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One command and the ticks to finish it, with random levels, idle ticks
    // after it, and now and then a command or spare opcode while it runs
    task automatic push_command(opcode_t op);
        int full, early, slack, noise_at, k;
        case (op)
            OP_RESET: begin
                early = span(REG_RESET_LOW) + span(REG_PRESENCE_WAIT);
                full = early + span(REG_RECOVERY);
            end
            OP_WBYTE, OP_WBIT: begin
                full = span(REG_WRITE_LEAD) + span(REG_SLOT) + span(REG_WRITE_TAIL);
                if (op == OP_WBYTE) full = full * 8;
                early = full;
            end
            default: begin
                full = span(REG_READ_LEAD) + span(REG_READ_SAMPLE) + span(REG_SLOT);
                if (op == OP_RBYTE) full = full * 8;
                early = full;
            end
        endcase
        slack = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
        noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, early - 1) : -1;
        push_item(op, pick_data(), 1'($urandom));
        for (k = 0; k < full + slack; k++) begin
            if (k == noise_at)
                push_item(3'($urandom_range(OP_RESET, OP_RBIT)), pick_data(), 1'($urandom));
            if ($urandom_range(0, 59) == 0)
                push_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                          8'($urandom), 1'($urandom));
            push_item(OP_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    function automatic opcode_t pick_op();
        return opcode_t'($urandom_range(OP_RESET, OP_RBIT));
    endfunction

    initial begin
        int i, start, n_phase;
        for (i = 0; i < 8; i++) cfg[i] = 12'(REG_RESET_VAL[i]);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pass: every phase one tick long
        apply_setting(SET_ZERO);
        push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_SPARE_6, 8'hFF, 1'b1);
        push_item(OP_SPARE_7, 8'h00, 1'b0);
        push_item(OP_RESET, 8'h00, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_TICK, 8'hFF, 1'b1);
        push_item(OP_RESET, 8'hFF, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_WBIT, 8'hFE, 1'b0);
        push_item(OP_RBYTE, 8'hFF, 1'b1);
        repeat (3) push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_WBIT, 8'h01, 1'b1);
        repeat (3) push_item(OP_TICK, 8'hFF, 1'b1);
        push_item(OP_RBIT, 8'h00, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_RBIT, 8'hFF, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b1);
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b1);
        wait_drained();

        apply_setting(SET_DEFAULT);
        push_command(OP_WBIT);
        push_command(OP_RBIT);
        wait_drained();

        apply_setting(SET_MAX);
        push_command(OP_WBIT);
        wait_drained();

        start = items_queued;
        n_phase = 0;
        while (items_queued - start < RANDOM_ITEMS) begin
            apply_setting((n_phase % 4 == 3) ? SET_ZERO : SET_RANDOM);
            i = items_queued;
            while (items_queued - i < 200) push_command(pick_op());
            wait_drained();
            n_phase++;
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && bus_status_q.size() == 0) begin
            $display("[one_wire_bus_master] OK");
        end else begin
            $display("[one_wire_bus_master] ERROR");
        end
        $finish;
    end

endmodule
